@@ rtl/core/bhdp_pkg.sv @@
// Shared types and constants for the bitstream header date parser.
// No dependencies; the top level, the datapath and the controller import this package.
`default_nettype none

package bhdp_pkg;

	localparam int DATE_LEN_DEF = 11;
	localparam int TIME_LEN_DEF = 9;

	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_EOF   = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_LEN = 2'd1;
	localparam logic [1:0] ST_KEY = 2'd2;
	localparam logic [1:0] ST_EOF = 2'd3;

	localparam logic KIND_TEXT   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0] KEY_A_CHR = 8'h61;
	localparam logic [7:0] KEY_B_CHR = 8'h62;
	localparam logic [7:0] KEY_C_CHR = 8'h63;
	localparam logic [7:0] KEY_D_CHR = 8'h64;
	localparam logic [7:0] KEY_E_CHR = 8'h65;
	localparam logic [7:0] SPACE_CHR = 8'h20;

	localparam logic [15:0] HDR_LEN = 16'd9;
	localparam logic [15:0] KEY_LEN = 16'd1;

	// controller to datapath
	typedef struct packed {
		logic       ld_len_hi;
		logic       ld_skip;
		logic       ld_date;
		logic       ld_time;
		logic       dec_skip;
		logic       store_text;
		logic       mark_space;
		logic       emit_start;
		logic       emit_load;
		logic       stat_load;
		logic [1:0] status;
		logic [7:0] key;
	} bhdp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic len_hdr_ok;
		logic len_one;
		logic len_zero;
		logic len_date_ok;
		logic len_time_ok;
		logic key_ok;
		logic skip_last;
		logic ptr_last;
		logic out_free;
	} bhdp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/bhdp_in_if.sv @@
// Input channel of the header parser: op code and file byte per beat.
// Stand-alone; no package needed.
`default_nettype none

interface bhdp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;

	modport source(output valid, output op, output data_byte, input ready);
	modport sink(input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bhdp_out_if.sv @@
// Result channel of the header parser: text character or final status per beat.
// Stand-alone; no package needed.
`default_nettype none

interface bhdp_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] text_char;
	logic [1:0] status;
	logic       last;

	modport source(output valid, output kind, output text_char, output status,
		output last, input ready);
	modport sink(input valid, input kind, input text_char, input status,
		input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bitstream_header_date_parser.sv @@
// Top level of the bitstream header date parser.
// Depends on bhdp_pkg, bhdp_in_if, bhdp_out_if, bhdp_ctrl and bhdp_dp.
//
// Usage:
//   in_ch carries one beat per file byte: op selects data byte, end of file
//   or start of a new file; data_byte is the raw byte. out_ch carries result
//   beats: text characters (date, one space, time) and one final status.
//   Header bytes are taken at one per cycle while no result is stalled in the
//   output register. The last time byte starts a text burst: the input is held
//   off while the buffered characters are read back, each by a RAM read and
//   then an output load, at most DATE_LEN + TIME_LEN + 1 beats. A status beat
//   appears in the cycle after the byte that causes it.
//   Results pass through a single output register; a new byte is accepted in
//   the same cycle the pending result is taken. A stalled receiver holds the
//   result and holds off input until it drains.
//   Reset (arst_n low) returns the walk to the header length; a start-new-file
//   beat does the same without a result. After a status beat, data and end of
//   file beats are dropped until a new file starts.
`default_nettype none

module bitstream_header_date_parser import bhdp_pkg::*; #(
	parameter int DATE_LEN = DATE_LEN_DEF,
	parameter int TIME_LEN = TIME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bhdp_in_if.sink     in_ch,
	bhdp_out_if.source  out_ch
);

	bhdp_cmd_t  cmd;
	bhdp_stat_t stat;

	// state machine: walks the header and sequences the text readout
	bhdp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.op      (in_ch.op),
		.in_ready(in_ch.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// counters, text buffer and the output register
	bhdp_dp #(
		.DATE_LEN(DATE_LEN),
		.TIME_LEN(TIME_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_byte(in_ch.data_byte),
		.cmd      (cmd),
		.stat     (stat),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire

@@ rtl/core/bhdp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bhdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 21,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/bhdp_dp.sv @@
// Datapath: length and skip counters, text buffer, output register.
// Depends on bhdp_pkg, bhdp_ram and bhdp_out_if.
`default_nettype none

module bhdp_dp import bhdp_pkg::*; #(
	parameter int DATE_LEN = DATE_LEN_DEF,
	parameter int TIME_LEN = TIME_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   data_byte,
	input  bhdp_cmd_t    cmd,
	output bhdp_stat_t   stat,
	bhdp_out_if.source   out_ch
);

	localparam int STORE_DEPTH = DATE_LEN + TIME_LEN + 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	logic [7:0]       length_high_q;
	logic [15:0]      bytes_left_q;
	logic [CNT_W-1:0] text_count_q;
	logic [CNT_W-1:0] space_idx_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic             nul_seen_q;
	logic             out_valid_q;
	logic             kind_q;
	logic [7:0]       char_q;
	logic [1:0]       status_q;
	logic             last_q;

	logic [15:0]      len;
	logic             store_en;
	logic [CNT_W-1:0] count_after;
	logic [7:0]       ram_rdata;
	logic [7:0]       emit_char;

	assign len         = {length_high_q, data_byte};
	assign store_en    = cmd.store_text && !nul_seen_q && (data_byte != 8'd0);
	assign count_after = text_count_q + CNT_W'(store_en);
	assign emit_char   = (rd_ptr_q == space_idx_q) ? SPACE_CHR : ram_rdata;

	always_comb begin
		stat.len_hdr_ok  = (len == HDR_LEN);
		stat.len_one     = (len == KEY_LEN);
		stat.len_zero    = (len == 16'd0);
		stat.len_date_ok = (len == 16'(DATE_LEN));
		stat.len_time_ok = (len == 16'(TIME_LEN));
		stat.key_ok      = (data_byte == cmd.key);
		stat.skip_last   = (bytes_left_q == 16'd1);
		stat.ptr_last    = ((rd_ptr_q + CNT_W'(1)) == text_count_q);
		stat.out_free    = !out_valid_q || out_ch.ready;
	end

	bhdp_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_text_ram (
		.clk  (clk),
		.we   (store_en),
		.waddr(text_count_q[ADDR_W-1:0]),
		.wdata(data_byte),
		.raddr(rd_ptr_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_high_q <= '0;
			bytes_left_q  <= '0;
			text_count_q  <= '0;
			space_idx_q   <= '0;
			rd_ptr_q      <= '0;
			nul_seen_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.ld_len_hi) begin
				length_high_q <= data_byte;
			end
			if (cmd.ld_skip) begin
				bytes_left_q <= len;
			end else if (cmd.ld_date) begin
				bytes_left_q <= 16'(DATE_LEN);
			end else if (cmd.ld_time) begin
				bytes_left_q <= 16'(TIME_LEN);
			end else if (cmd.dec_skip || cmd.store_text) begin
				bytes_left_q <= bytes_left_q - 16'd1;
			end
			if (cmd.ld_date) begin
				text_count_q <= '0;
				nul_seen_q   <= 1'b0;
			end else if (cmd.ld_time) begin
				nul_seen_q <= 1'b0;
			end else if (cmd.store_text) begin
				// the separator slot sits right after the last date character
				text_count_q <= count_after + CNT_W'(cmd.mark_space);
				if (data_byte == 8'd0) begin
					nul_seen_q <= 1'b1;
				end
			end
			if (cmd.mark_space) begin
				space_idx_q <= count_after;
			end
			if (cmd.emit_start) begin
				rd_ptr_q <= '0;
			end else if (cmd.emit_load) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			if (cmd.emit_load || cmd.stat_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			kind_q   <= KIND_TEXT;
			char_q   <= emit_char;
			status_q <= ST_OK;
			last_q   <= stat.ptr_last;
		end else if (cmd.stat_load) begin
			kind_q   <= KIND_STATUS;
			char_q   <= 8'd0;
			status_q <= cmd.status;
			last_q   <= 1'b1;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.kind      = kind_q;
	assign out_ch.text_char = char_q;
	assign out_ch.status    = status_q;
	assign out_ch.last      = last_q;

endmodule

`default_nettype wire

@@ rtl/core/bhdp_ctrl.sv @@
// Controller: header walk state machine and text readout sequencing.
// Depends on bhdp_pkg.
`default_nettype none

module bhdp_ctrl import bhdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	output logic       in_ready,
	input  bhdp_stat_t stat,
	output bhdp_cmd_t  cmd
);

	localparam logic [4:0] PH_HDR_HI    = 5'd0;
	localparam logic [4:0] PH_HDR_LO    = 5'd1;
	localparam logic [4:0] PH_HDR_SKIP  = 5'd2;
	localparam logic [4:0] PH_A_HI      = 5'd3;
	localparam logic [4:0] PH_A_LO      = 5'd4;
	localparam logic [4:0] PH_KEY_A     = 5'd5;
	localparam logic [4:0] PH_NAME_HI   = 5'd6;
	localparam logic [4:0] PH_NAME_LO   = 5'd7;
	localparam logic [4:0] PH_NAME_SKIP = 5'd8;
	localparam logic [4:0] PH_KEY_B     = 5'd9;
	localparam logic [4:0] PH_PART_HI   = 5'd10;
	localparam logic [4:0] PH_PART_LO   = 5'd11;
	localparam logic [4:0] PH_PART_SKIP = 5'd12;
	localparam logic [4:0] PH_KEY_C     = 5'd13;
	localparam logic [4:0] PH_DATE_HI   = 5'd14;
	localparam logic [4:0] PH_DATE_LO   = 5'd15;
	localparam logic [4:0] PH_DATE_DATA = 5'd16;
	localparam logic [4:0] PH_KEY_D     = 5'd17;
	localparam logic [4:0] PH_TIME_HI   = 5'd18;
	localparam logic [4:0] PH_TIME_LO   = 5'd19;
	localparam logic [4:0] PH_TIME_DATA = 5'd20;
	localparam logic [4:0] PH_KEY_E     = 5'd21;
	localparam logic [4:0] PH_DONE      = 5'd22;
	localparam logic [4:0] PH_EMIT_RD   = 5'd23;
	localparam logic [4:0] PH_EMIT_WR   = 5'd24;

	logic [4:0] phase_q;
	logic [4:0] phase_d;
	logic       emitting;
	logic       acc;

	assign emitting = (phase_q == PH_EMIT_RD) || (phase_q == PH_EMIT_WR);
	assign in_ready = !emitting && stat.out_free;
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		phase_d = phase_q;

		case (phase_q)
			PH_KEY_A: cmd.key = KEY_A_CHR;
			PH_KEY_B: cmd.key = KEY_B_CHR;
			PH_KEY_C: cmd.key = KEY_C_CHR;
			PH_KEY_D: cmd.key = KEY_D_CHR;
			default:  cmd.key = KEY_E_CHR;
		endcase

		if (phase_q == PH_EMIT_RD) begin
			phase_d = PH_EMIT_WR;
		end else if (phase_q == PH_EMIT_WR) begin
			if (stat.out_free) begin
				cmd.emit_load = 1'b1;
				phase_d = stat.ptr_last ? PH_KEY_E : PH_EMIT_RD;
			end
		end else if (acc) begin
			case (op)
				OP_START: begin
					phase_d = PH_HDR_HI;
				end
				OP_EOF: begin
					if (phase_q != PH_DONE) begin
						cmd.stat_load = 1'b1;
						cmd.status    = ST_EOF;
						phase_d       = PH_DONE;
					end
				end
				OP_DATA: begin
					case (phase_q)
						PH_HDR_HI, PH_A_HI, PH_NAME_HI, PH_PART_HI, PH_DATE_HI,
						PH_TIME_HI: begin
							cmd.ld_len_hi = 1'b1;
							phase_d = phase_q + 5'd1;
						end
						PH_HDR_LO: begin
							if (stat.len_hdr_ok) begin
								cmd.ld_skip = 1'b1;
								phase_d = PH_HDR_SKIP;
							end else begin
								cmd.stat_load = 1'b1;
								cmd.status    = ST_LEN;
								phase_d       = PH_DONE;
							end
						end
						PH_A_LO: begin
							if (stat.len_one) begin
								phase_d = PH_KEY_A;
							end else begin
								cmd.stat_load = 1'b1;
								cmd.status    = ST_LEN;
								phase_d       = PH_DONE;
							end
						end
						PH_NAME_LO: begin
							if (stat.len_zero) begin
								phase_d = PH_KEY_B;
							end else begin
								cmd.ld_skip = 1'b1;
								phase_d = PH_NAME_SKIP;
							end
						end
						PH_PART_LO: begin
							if (stat.len_zero) begin
								phase_d = PH_KEY_C;
							end else begin
								cmd.ld_skip = 1'b1;
								phase_d = PH_PART_SKIP;
							end
						end
						PH_HDR_SKIP: begin
							cmd.dec_skip = 1'b1;
							if (stat.skip_last) begin
								phase_d = PH_A_HI;
							end
						end
						PH_NAME_SKIP: begin
							cmd.dec_skip = 1'b1;
							if (stat.skip_last) begin
								phase_d = PH_KEY_B;
							end
						end
						PH_PART_SKIP: begin
							cmd.dec_skip = 1'b1;
							if (stat.skip_last) begin
								phase_d = PH_KEY_C;
							end
						end
						PH_KEY_A, PH_KEY_B, PH_KEY_C, PH_KEY_D: begin
							if (stat.key_ok) begin
								case (phase_q)
									PH_KEY_A: phase_d = PH_NAME_HI;
									PH_KEY_B: phase_d = PH_PART_HI;
									PH_KEY_C: phase_d = PH_DATE_HI;
									default:  phase_d = PH_TIME_HI;
								endcase
							end else begin
								cmd.stat_load = 1'b1;
								cmd.status    = ST_KEY;
								phase_d       = PH_DONE;
							end
						end
						PH_KEY_E: begin
							cmd.stat_load = 1'b1;
							cmd.status    = stat.key_ok ? ST_OK : ST_KEY;
							phase_d       = PH_DONE;
						end
						PH_DATE_LO: begin
							if (stat.len_date_ok) begin
								cmd.ld_date = 1'b1;
								phase_d = PH_DATE_DATA;
							end else begin
								cmd.stat_load = 1'b1;
								cmd.status    = ST_LEN;
								phase_d       = PH_DONE;
							end
						end
						PH_TIME_LO: begin
							if (stat.len_time_ok) begin
								cmd.ld_time = 1'b1;
								phase_d = PH_TIME_DATA;
							end else begin
								cmd.stat_load = 1'b1;
								cmd.status    = ST_LEN;
								phase_d       = PH_DONE;
							end
						end
						PH_DATE_DATA: begin
							cmd.store_text = 1'b1;
							if (stat.skip_last) begin
								cmd.mark_space = 1'b1;
								phase_d = PH_KEY_D;
							end
						end
						PH_TIME_DATA: begin
							cmd.store_text = 1'b1;
							if (stat.skip_last) begin
								cmd.emit_start = 1'b1;
								phase_d = PH_EMIT_RD;
							end
						end
						PH_DONE: begin
							phase_d = PH_DONE;
						end
						default: begin
							phase_d = PH_DONE;
						end
					endcase
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_HI;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire
